[hw/rtl/cpe_pkg.sv]
// shared types, constants and microcode table for the chebyshev polynomial evaluator
// no dependencies; used by cpe_sequencer, cpe_datapath and the top level
package cpe_pkg;

  localparam int MAX_DEGREE = 255;
  localparam int DEGREE_W   = 8;
  localparam int DATA_W     = 32;
  localparam int CNT_W      = $clog2(MAX_DEGREE + 1);
  localparam int PC_W       = 3;
  localparam int CFG_IDX_W  = 2;

  localparam logic [DATA_W-1:0] SCALE_RESET = 32'h0100_0000;
  localparam logic [DATA_W-1:0] Q_ONE       = 32'h0100_0000;

  localparam logic [CFG_IDX_W-1:0] CFG_DEGREE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd2;

  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_LOAD_X,
    ACT_MUL,
    ACT_Y,
    ACT_REC,
    ACT_FIN
  } act_t;

  typedef enum logic {
    MSEL_SCALE_X,
    MSEL_Y_P1
  } msel_t;

  typedef enum logic [1:0] {
    WAIT_NONE,
    WAIT_IN,
    WAIT_OUT
  } wait_t;

  typedef enum logic [1:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_CNT_ZERO,
    COND_LOOP
  } cond_t;

  typedef struct packed {
    act_t  act;
    msel_t msel;
    wait_t wt;
    cond_t cond;
    pc_t   target;
  } uword_t;

  typedef struct packed {
    act_t  act;
    msel_t msel;
    logic  fire;
  } ctrl_t;

  localparam pc_t PC_WAIT  = 3'd0;
  localparam pc_t PC_LOOP  = 3'd3;
  localparam pc_t PC_FINAL = 3'd5;

  function automatic uword_t ucode(input pc_t pc);
    uword_t w;
    case (pc)
      3'd0:    w = '{ACT_LOAD_X, MSEL_SCALE_X, WAIT_IN,   COND_NEXT,     PC_WAIT};
      3'd1:    w = '{ACT_MUL,    MSEL_SCALE_X, WAIT_NONE, COND_NEXT,     PC_WAIT};
      3'd2:    w = '{ACT_Y,      MSEL_SCALE_X, WAIT_NONE, COND_CNT_ZERO, PC_FINAL};
      3'd3:    w = '{ACT_MUL,    MSEL_Y_P1,    WAIT_NONE, COND_NEXT,     PC_WAIT};
      3'd4:    w = '{ACT_REC,    MSEL_Y_P1,    WAIT_NONE, COND_LOOP,     PC_LOOP};
      3'd5:    w = '{ACT_MUL,    MSEL_Y_P1,    WAIT_NONE, COND_NEXT,     PC_WAIT};
      3'd6:    w = '{ACT_FIN,    MSEL_Y_P1,    WAIT_OUT,  COND_ALWAYS,   PC_WAIT};
      default: w = '{ACT_NONE,   MSEL_SCALE_X, WAIT_NONE, COND_ALWAYS,   PC_WAIT};
    endcase
    return w;
  endfunction

endpackage

[hw/rtl/cpe_sequencer.sv]
// microcode sequencer: step counter, control table lookup, loop counter and jumps
// depends on cpe_pkg
module cpe_sequencer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          out_busy,
  input  logic [cpe_pkg::DEGREE_W-1:0]  degree,
  output logic                          in_ready,
  output cpe_pkg::ctrl_t                ctrl
);

  cpe_pkg::pc_t    pc;
  cpe_pkg::pc_t    pc_next;
  cpe_pkg::uword_t uw;
  logic [cpe_pkg::CNT_W-1:0] cnt;
  logic [cpe_pkg::CNT_W-1:0] cnt_next;
  logic [cpe_pkg::CNT_W-1:0] n_clamped;
  logic go;
  logic jump;

  assign uw = cpe_pkg::ucode(pc);

  always_comb begin
    case (uw.wt)
      cpe_pkg::WAIT_IN:  go = in_valid;
      cpe_pkg::WAIT_OUT: go = !out_busy;
      default:           go = 1'b1;
    endcase
  end

  assign in_ready  = (uw.wt == cpe_pkg::WAIT_IN);
  assign ctrl.act  = uw.act;
  assign ctrl.msel = uw.msel;
  assign ctrl.fire = go;

  always_comb begin
    if (int'(degree) > cpe_pkg::MAX_DEGREE) begin
      n_clamped = cpe_pkg::CNT_W'(cpe_pkg::MAX_DEGREE);
    end else begin
      n_clamped = cpe_pkg::CNT_W'(degree);
    end
  end

  always_comb begin
    case (uw.cond)
      cpe_pkg::COND_ALWAYS:   jump = 1'b1;
      cpe_pkg::COND_CNT_ZERO: jump = (cnt == '0);
      cpe_pkg::COND_LOOP:     jump = (cnt != cpe_pkg::CNT_W'(1));
      default:                jump = 1'b0;
    endcase
  end

  always_comb begin
    cnt_next = cnt;
    pc_next  = pc;
    if (go) begin
      pc_next = jump ? uw.target : pc + cpe_pkg::PC_W'(1);
      if (uw.act == cpe_pkg::ACT_LOAD_X) begin
        // recurrence runs n-1 times, none for n below two
        cnt_next = (n_clamped >= cpe_pkg::CNT_W'(2)) ? n_clamped - cpe_pkg::CNT_W'(1) : '0;
      end else if (uw.act == cpe_pkg::ACT_REC) begin
        cnt_next = cnt - cpe_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc  <= cpe_pkg::PC_WAIT;
      cnt <= '0;
    end else begin
      pc  <= pc_next;
      cnt <= cnt_next;
    end
  end

endmodule

[hw/rtl/cpe_datapath.sv]
// datapath: one registered 32x32 multiplier, rounding add/subtract with saturation,
// recurrence registers and the output register; depends on cpe_pkg
module cpe_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  cpe_pkg::ctrl_t                    ctrl,
  input  logic signed [cpe_pkg::DATA_W-1:0] sample,
  input  logic signed [cpe_pkg::DATA_W-1:0] scale,
  input  logic signed [cpe_pkg::DATA_W-1:0] offset,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic signed [cpe_pkg::DATA_W-1:0] value,
  output logic                              saturated,
  output logic                              out_busy
);

  localparam int PROD_W = 2 * cpe_pkg::DATA_W;
  localparam int RND_W  = PROD_W - 24;
  localparam int ACC_W  = RND_W + 2;

  logic signed [cpe_pkg::DATA_W-1:0] x;
  logic signed [cpe_pkg::DATA_W-1:0] y;
  logic signed [cpe_pkg::DATA_W-1:0] p1;
  logic signed [cpe_pkg::DATA_W-1:0] p2;
  logic signed [PROD_W-1:0]          prod;
  logic                              flag;

  logic signed [cpe_pkg::DATA_W-1:0] mul_a;
  logic signed [cpe_pkg::DATA_W-1:0] mul_b;
  logic signed [PROD_W-1:0]          prod_rnd;
  logic signed [RND_W-1:0]           rnd;
  logic signed [ACC_W-1:0]           acc_a;
  logic signed [ACC_W-1:0]           acc_b;
  logic signed [ACC_W-1:0]           acc;
  logic signed [cpe_pkg::DATA_W-1:0] acc_sat;
  logic                              clip;
  logic                              fin_fire;

  assign mul_a = (ctrl.msel == cpe_pkg::MSEL_SCALE_X) ? scale : y;
  assign mul_b = (ctrl.msel == cpe_pkg::MSEL_SCALE_X) ? x : p1;

  // round half up, then floor shift by 24
  assign prod_rnd = prod + PROD_W'(64'sd8388608);
  assign rnd      = prod_rnd[PROD_W-1:24];

  always_comb begin
    case (ctrl.act)
      cpe_pkg::ACT_Y: begin
        acc_a = ACC_W'(rnd);
        acc_b = ACC_W'(offset);
      end
      cpe_pkg::ACT_REC: begin
        acc_a = ACC_W'(rnd) <<< 1;
        acc_b = -ACC_W'(p2);
      end
      default: begin
        acc_a = ACC_W'(rnd);
        acc_b = -ACC_W'(p2);
      end
    endcase
  end

  assign acc = acc_a + acc_b;

  always_comb begin
    clip = (acc[ACC_W-1:cpe_pkg::DATA_W-1] != '0) && (acc[ACC_W-1:cpe_pkg::DATA_W-1] != '1);
    if (!clip) begin
      acc_sat = acc[cpe_pkg::DATA_W-1:0];
    end else if (acc[ACC_W-1]) begin
      acc_sat = {1'b1, {(cpe_pkg::DATA_W-1){1'b0}}};
    end else begin
      acc_sat = {1'b0, {(cpe_pkg::DATA_W-1){1'b1}}};
    end
  end

  assign fin_fire = ctrl.fire && (ctrl.act == cpe_pkg::ACT_FIN);
  assign out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (ctrl.fire) begin
      case (ctrl.act)
        cpe_pkg::ACT_LOAD_X: begin
          x    <= sample;
          flag <= 1'b0;
        end
        cpe_pkg::ACT_MUL: begin
          prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
        end
        cpe_pkg::ACT_Y: begin
          y    <= acc_sat;
          p1   <= '0;
          p2   <= -$signed(cpe_pkg::Q_ONE);
          flag <= flag | clip;
        end
        cpe_pkg::ACT_REC: begin
          p2   <= p1;
          p1   <= acc_sat;
          flag <= flag | clip;
        end
        cpe_pkg::ACT_FIN: begin
          value     <= acc_sat;
          saturated <= flag | clip;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

[hw/rtl/chebyshev_polynomial_evaluator_unit.sv]
// the degree is clamped to MAX_DEGREE; each recurrence step goes through the shared
// multiplier and then the saturating adder; the next input beat is taken in the cycle
// after the result is written, so one item is finished before the next is accepted
// reset: synchronous, clears the sequencer and output valid; degree 0, scale 1.0, offset 0
// top level; depends on cpe_pkg, cpe_sequencer, cpe_datapath
module chebyshev_polynomial_evaluator_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [cpe_pkg::DATA_W-1:0]   sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [cpe_pkg::DATA_W-1:0]   value,
  output logic                                saturated,
  input  logic                                cfg_we,
  input  logic [cpe_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cpe_pkg::DATA_W-1:0]          cfg_data
);

  logic [cpe_pkg::DEGREE_W-1:0]      degree;
  logic signed [cpe_pkg::DATA_W-1:0] scale;
  logic signed [cpe_pkg::DATA_W-1:0] offset;
  cpe_pkg::ctrl_t                    ctrl;
  logic                              out_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      degree <= '0;
      scale  <= cpe_pkg::SCALE_RESET;
      offset <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        cpe_pkg::CFG_DEGREE: degree <= cfg_data[cpe_pkg::DEGREE_W-1:0];
        cpe_pkg::CFG_SCALE:  scale  <= cfg_data;
        cpe_pkg::CFG_OFFSET: offset <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  cpe_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .out_busy (out_busy),
    .degree   (degree),
    .in_ready (in_ready),
    .ctrl     (ctrl)
  );

  cpe_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .sample    (sample),
    .scale     (scale),
    .offset    (offset),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .value     (value),
    .saturated (saturated),
    .out_busy  (out_busy)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in a row");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctrl.fire && ctrl.act == cpe_pkg::ACT_FIN |-> !out_busy)
    else $error("result written over a pending output");

  a_fin_sets_valid: assert property (@(posedge clk) disable iff (rst)
    ctrl.fire && ctrl.act == cpe_pkg::ACT_FIN |=> out_valid && in_ready)
    else $error("final step did not post a result");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("reset left output valid or sequencer busy");

endmodule

[test/chebyshev_polynomial_evaluator_unit_test.sv]
`timescale 1ns / 1ps
// testbench for chebyshev_polynomial_evaluator_unit: a directed stimulus table, then random
// register settings and samples, each result beat checked against a table value or a
// fixed-point recurrence model; depends on cpe_pkg and the unit's rtl
module chebyshev_polynomial_evaluator_unit_test;

  localparam int     HALF_PERIOD   = 2;
  localparam int     CYCLE_LIMIT   = 2000000;
  localparam int     RANDOM_ITEMS  = 400;
  localparam int     SETTLE_CYCLES = 3;
  localparam int     TAIL_CYCLES   = 20;
  localparam int     Q_UNIT        = 1 << 24;
  localparam longint Q_ROUND       = 64'sd8388608;
  localparam longint Q_MAX         = 64'sd2147483647;
  localparam longint Q_MIN         = -64'sd2147483648;
  localparam logic [cpe_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic signed [cpe_pkg::DATA_W-1:0] value;
    logic                              saturated;
  } cheb_result_t;

  typedef enum logic {
    ROW_REG,
    ROW_SAMPLE
  } row_kind_t;

  typedef struct packed {
    row_kind_t                     kind;
    logic [cpe_pkg::CFG_IDX_W-1:0] index;
    logic [cpe_pkg::DATA_W-1:0]    data;
    logic                          typed;
    logic [cpe_pkg::DATA_W-1:0]    value;
    logic                          saturated;
  } directed_row_t;

  localparam int DIRECTED_ROWS = 29;
  localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{ROW_SAMPLE, '0,                  32'h0000_0000, 1'b1, 32'h0100_0000, 1'b0},
    '{ROW_SAMPLE, '0,                  32'h7fff_ffff, 1'b1, 32'h0100_0000, 1'b0},
    '{ROW_SAMPLE, '0,                  32'h8000_0000, 1'b1, 32'h0100_0000, 1'b0},
    '{ROW_REG,    cpe_pkg::CFG_DEGREE, 32'h0000_0001, 1'b0, 32'h0000_0000, 1'b0},
    '{ROW_REG,    cpe_pkg::CFG_SCALE,  32'h7fff_ffff, 1'b0, 32'h0000_0000, 1'b0},
    '{ROW_SAMPLE, '0,                  32'h7fff_ffff, 1'b1, 32'h0100_0000, 1'b1},
    '{ROW_REG,    cpe_pkg::CFG_SCALE,  32'h8000_0000, 1'b0, 32'h0000_0000, 1'b0},
    '{ROW_SAMPLE, '0,                  32'h8000_0000, 1'b1, 32'h0100_0000, 1'b1},
    '{ROW_SAMPLE, '0,                  32'h0000_0000, 1'b1, 32'h0100_0000, 1'b0},
    '{ROW_REG,    cpe_pkg::CFG_SCALE,  32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
    '{ROW_REG,    cpe_pkg::CFG_OFFSET, 32'h7fff_ffff, 1'b0, 32'h0000_0000, 1'b0},
    '{ROW_REG,    cpe_pkg::CFG_DEGREE, 32'h0000_0002, 1'b0, 32'h0000_0000, 1'b0},
    '{ROW_SAMPLE, '0,                  32'h1234_5678, 1'b1, 32'h7fff_ffff, 1'b0},
    '{ROW_REG,    cpe_pkg::CFG_OFFSET, 32'h8000_0000, 1'b0, 32'h0000_0000, 1'b0},
    '{ROW_SAMPLE, '0,                  32'h0000_0000, 1'b1, 32'h8000_0000, 1'b0},
    // write to an unmapped index leaves every register alone
    '{ROW_REG,    CFG_UNUSED,          32'h0000_00ff, 1'b0, 32'h0000_0000, 1'b0},
    '{ROW_SAMPLE, '0,                  32'hffff_ffff, 1'b1, 32'h8000_0000, 1'b0},
    '{ROW_REG,    cpe_pkg::CFG_DEGREE, 32'h0000_0003, 1'b0, 32'h0000_0000, 1'b0},
    '{ROW_SAMPLE, '0,                  32'h0000_0000, 1'b1, 32'h7fff_ffff, 1'b1},
    '{ROW_REG,    cpe_pkg::CFG_SCALE,  32'h0100_0000, 1'b0, 32'h0000_0000, 1'b0},
    '{ROW_REG,    cpe_pkg::CFG_OFFSET, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
    '{ROW_REG,    cpe_pkg::CFG_DEGREE, 32'h0000_00ff, 1'b0, 32'h0000_0000, 1'b0},
    '{ROW_SAMPLE, '0,                  32'h0100_0000, 1'b0, 32'h0000_0000, 1'b0},
    '{ROW_SAMPLE, '0,                  32'hff00_0000, 1'b0, 32'h0000_0000, 1'b0},
    '{ROW_SAMPLE, '0,                  32'h0080_0000, 1'b0, 32'h0000_0000, 1'b0},
    '{ROW_SAMPLE, '0,                  32'h00b5_04f3, 1'b0, 32'h0000_0000, 1'b0},
    '{ROW_REG,    cpe_pkg::CFG_DEGREE, 32'h0000_0005, 1'b0, 32'h0000_0000, 1'b0},
    '{ROW_SAMPLE, '0,                  32'hfe00_0000, 1'b0, 32'h0000_0000, 1'b0},
    '{ROW_SAMPLE, '0,                  32'h0000_0001, 1'b0, 32'h0000_0000, 1'b0}
  };

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic signed [cpe_pkg::DATA_W-1:0] sample = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic signed [cpe_pkg::DATA_W-1:0] value;
  logic                              saturated;
  logic                              cfg_we = 1'b0;
  logic [cpe_pkg::CFG_IDX_W-1:0]     cfg_index = cpe_pkg::CFG_DEGREE;
  logic [cpe_pkg::DATA_W-1:0]        cfg_data = '0;

  logic [cpe_pkg::DEGREE_W-1:0]      model_degree = '0;
  logic signed [cpe_pkg::DATA_W-1:0] model_scale = cpe_pkg::SCALE_RESET;
  logic signed [cpe_pkg::DATA_W-1:0] model_offset = '0;

  cheb_result_t pending_results[$];
  int           error_count = 0;
  int           cycle_count = 0;
  logic         quiet = 1'b0;

  chebyshev_polynomial_evaluator_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample    (sample),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value     (value),
    .saturated (saturated),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #(HALF_PERIOD) clk = 1'b1;
    #(HALF_PERIOD) clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic longint q_mul(input longint a, input longint b);
    return (a * b + Q_ROUND) >>> 24;
  endfunction

  function automatic logic out_of_range(input longint v);
    return (v > Q_MAX) || (v < Q_MIN);
  endfunction

  function automatic longint clip_q(input longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  function automatic cheb_result_t chebyshev_eval(input logic signed [cpe_pkg::DATA_W-1:0] x);
    cheb_result_t r;
    longint       y;
    longint       d_prev;
    longint       d_prev2;
    longint       t;
    int           steps;
    logic         hit;
    hit = 1'b0;
    t = q_mul(model_scale, x) + model_offset;
    hit |= out_of_range(t);
    y = clip_q(t);
    d_prev2 = -Q_UNIT;
    d_prev = 0;
    steps = (model_degree > cpe_pkg::MAX_DEGREE) ? cpe_pkg::MAX_DEGREE : model_degree;
    for (int j = steps; j >= 2; j--) begin
      t = 2 * q_mul(y, d_prev) - d_prev2;
      hit |= out_of_range(t);
      d_prev2 = d_prev;
      d_prev = clip_q(t);
    end
    t = q_mul(y, d_prev) - d_prev2;
    hit |= out_of_range(t);
    r.value = cpe_pkg::DATA_W'(clip_q(t));
    r.saturated = hit;
    return r;
  endfunction

  function automatic logic signed [cpe_pkg::DATA_W-1:0] near_zero(input int span);
    return cpe_pkg::DATA_W'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic logic signed [cpe_pkg::DATA_W-1:0] wide_value();
    case ($urandom_range(0, 3))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_sample(input logic signed [cpe_pkg::DATA_W-1:0] x,
                             input cheb_result_t want);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 8);
    cfg_we <= 1'b0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample <= x;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(want);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    cfg_we <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [cpe_pkg::CFG_IDX_W-1:0] idx,
                           input logic [cpe_pkg::DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      cpe_pkg::CFG_DEGREE: model_degree = data[cpe_pkg::DEGREE_W-1:0];
      cpe_pkg::CFG_SCALE:  model_scale = data;
      cpe_pkg::CFG_OFFSET: model_offset = data;
      default: ;
    endcase
  endtask

  // result beat checker
  always @(posedge clk) begin
    cheb_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t unexpected beat: expected none, actual value %h saturated %b",
                 $time, value, saturated);
      end else begin
        want = pending_results.pop_front();
        if (value !== want.value) begin
          error_count++;
          $display("%0t value mismatch: expected %h, actual %h", $time, want.value, value);
        end
        if (saturated !== want.saturated) begin
          error_count++;
          $display("%0t saturated mismatch: expected %b, actual %b",
                   $time, want.saturated, saturated);
        end
      end
    end
  end

  // result side back-pressure
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 8);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    directed_row_t                     row;
    cheb_result_t                      want;
    logic signed [cpe_pkg::DATA_W-1:0] x;
    logic [cpe_pkg::DEGREE_W-1:0]      deg;
    logic signed [cpe_pkg::DATA_W-1:0] scl;
    logic signed [cpe_pkg::DATA_W-1:0] ofs;
    logic                              well_formed;
    int                                batch;
    int                                random_done;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      row = DIRECTED[i];
      if (row.kind == ROW_REG) begin
        drain();
        write_reg(row.index, row.data);
      end else begin
        if (row.typed) begin
          want.value = row.value;
          want.saturated = row.saturated;
        end else begin
          want = chebyshev_eval(row.data);
        end
        push_sample(row.data, want);
      end
    end

    random_done = 0;
    while (random_done < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       deg = cpe_pkg::DEGREE_W'(cpe_pkg::MAX_DEGREE);
        1:       deg = cpe_pkg::DEGREE_W'($urandom_range(11, 254));
        2:       deg = '0;
        default: deg = cpe_pkg::DEGREE_W'($urandom_range(1, 10));
      endcase
      well_formed = ($urandom_range(0, 3) != 0);
      if (well_formed) begin
        scl = near_zero(Q_UNIT);
        ofs = near_zero(Q_UNIT / 4);
      end else begin
        scl = ($urandom_range(0, 4) == 0) ? '0 : wide_value();
        ofs = wide_value();
      end
      drain();
      write_reg(cpe_pkg::CFG_DEGREE, {{(cpe_pkg::DATA_W-cpe_pkg::DEGREE_W){1'b0}}, deg});
      write_reg(cpe_pkg::CFG_SCALE, scl);
      write_reg(cpe_pkg::CFG_OFFSET, ofs);
      quiet = ($urandom_range(0, 4) == 0);
      batch = (deg > 16) ? 6 : 32;
      repeat (batch) begin
        // now and then, hold off until the unit has emptied
        if ($urandom_range(0, 29) == 0) drain();
        if (well_formed ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 1) != 0))
          x = near_zero(Q_UNIT);
        else
          x = wide_value();
        push_sample(x, chebyshev_eval(x));
        random_done++;
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[chebyshev_polynomial_evaluator_unit.f]
hw/rtl/cpe_pkg.sv
hw/rtl/cpe_sequencer.sv
hw/rtl/cpe_datapath.sv
hw/rtl/chebyshev_polynomial_evaluator_unit.sv
test/chebyshev_polynomial_evaluator_unit_test.sv
